// ===== rtl/point_pair_heading_angle_top_macros.svh =====
// Assertion macros shared by the point-pair heading angle RTL.
`ifndef POINT_PAIR_HEADING_ANGLE_TOP_MACROS_SVH
`define POINT_PAIR_HEADING_ANGLE_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define PPHA_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heading angle check failed");

// Check that a condition implies another in the next cycle.
`define PPHA_IMPLIES_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heading angle check failed");

`endif

// ===== rtl/ppha_pkg.sv =====
// Package: types, constants and arctangent table for the point-pair heading angle block.
package ppha_pkg;

    localparam int COORD_BITS           = 16;
    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int TABLE_LEN            = 24;
    localparam int PRE_SHIFT            = 24;
    localparam int DIFF_W               = COORD_BITS + 1;
    localparam int CORDIC_W             = DIFF_W + PRE_SHIFT + 3;
    localparam int Z_W                  = 34;
    localparam int RAD_W                = 16;
    localparam int DEG_W                = 16;
    localparam int RAD_SHIFT            = 17;
    localparam int DEG_SHIFT            = 47;
    localparam int K_W                  = 31;
    localparam int PROD_W               = Z_W + K_W;

    localparam logic signed [Z_W-1:0]    PI_Q30          = 34'sd3373259426;
    localparam logic signed [Z_W-1:0]    HALF_PI_Q30     = 34'sd1686629713;
    localparam logic signed [K_W-1:0]    DEG_PER_RAD_Q24 = 31'sd961263669;
    localparam logic signed [Z_W-1:0]    RAD_ROUND       = Z_W'(1) << (RAD_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] DEG_ROUND       = PROD_W'(1) << (DEG_SHIFT - 1);
    localparam logic signed [RAD_W-1:0]  RAD_MAX         = 16'sd25736;
    localparam logic signed [DEG_W-1:0]  DEG_MAX         = 16'sd23040;

    localparam logic [2:0] MODE_ZERO     = 3'd0;
    localparam logic [2:0] MODE_PI       = 3'd1;
    localparam logic [2:0] MODE_HALF_POS = 3'd2;
    localparam logic [2:0] MODE_HALF_NEG = 3'd3;
    localparam logic [2:0] MODE_CORDIC   = 3'd4;

    localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef struct packed {
        logic signed [COORD_BITS-1:0] from_x;
        logic signed [COORD_BITS-1:0] from_y;
        logic signed [COORD_BITS-1:0] to_x;
        logic signed [COORD_BITS-1:0] to_y;
    } pair_t;

    typedef struct packed {
        logic signed [RAD_W-1:0] angle_radians;
        logic signed [DEG_W-1:0] angle_degrees;
    } heading_t;

    typedef struct packed {
        logic [2:0]                 mode;
        logic                       a_neg;
        logic                       b_neg;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [Z_W-1:0]      z;
    } cordic_t;

endpackage

// ===== rtl/ppha_cordic_stage.sv =====
// One registered CORDIC vectoring micro-rotation with valid/ready flow control.
module ppha_cordic_stage
    import ppha_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    src_valid,
    output logic    src_ready,
    input  cordic_t src,
    output logic    dst_valid,
    input  logic    dst_ready,
    output cordic_t dst
);

    logic                       valid_reg;
    cordic_t                    beat_reg;
    cordic_t                    beat_next;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [Z_W-1:0]      step;

    assign xs   = src.x >>> SHIFT;
    assign ys   = src.y >>> SHIFT;
    assign step = Z_W'(ATAN_TABLE[SHIFT]);

    always_comb
    begin
        beat_next = src;
        if (src.y > 0)
        begin
            beat_next.x = src.x + ys;
            beat_next.y = src.y - xs;
            beat_next.z = src.z + step;
        end
        else
        begin
            beat_next.x = src.x - ys;
            beat_next.y = src.y + xs;
            beat_next.z = src.z - step;
        end
    end

    assign src_ready = !valid_reg || dst_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (src_ready)
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_ready && src_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    assign dst_valid = valid_reg;
    assign dst       = beat_reg;

endmodule

// ===== rtl/point_pair_heading_angle_top.sv =====
// Top level: pipelined CORDIC heading angle of a point pair in radians and degrees.
// Each beat on pair gives one beat on heading: atan2(from_x - to_x, from_y - to_y) in
// signed Q3.13 radians, range (-pi, pi], and its negation in signed Q9.7 degrees.
// The pipeline takes one beat per cycle unless the output stalls, and has these stages:
// an input stage, one register stage per CORDIC micro-rotation, a quadrant
// stage, a degree-scaling multiply stage and the output register. Every stage has its
// own valid bit and accepts a new beat whenever it is empty or its successor moves, so
// a stalled output fills the pipeline before pair_ready drops. No state is kept
// between beats.
`include "point_pair_heading_angle_top_macros.svh"

module point_pair_heading_angle_top
    import ppha_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pair_valid,
    output logic     pair_ready,
    input  pair_t    pair,
    output logic     heading_valid,
    input  logic     heading_ready,
    output heading_t heading
);

    localparam int N = ANGLE_ITERATIONS;

    logic    cv [0:N];
    logic    cr [0:N];
    cordic_t cd [0:N];

    logic    s0_valid_reg;
    cordic_t s0_beat_reg;
    cordic_t s0_beat_next;

    logic signed [DIFF_W-1:0] a_diff;
    logic signed [DIFF_W-1:0] b_diff;
    logic [DIFF_W-1:0]        a_mag;
    logic [DIFF_W-1:0]        b_mag;

    logic                  q_valid_reg;
    logic                  q_ready;
    logic signed [Z_W-1:0] theta_reg;
    logic signed [Z_W-1:0] theta_next;
    logic signed [Z_W-1:0] theta_half;

    logic                     m_valid_reg;
    logic                     m_ready;
    logic signed [Z_W-1:0]    neg_theta;
    logic signed [Z_W-1:0]    rad_sum;
    logic signed [RAD_W-1:0]  rad_reg;
    logic signed [RAD_W-1:0]  rad_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    logic                     o_valid_reg;
    logic                     o_ready;
    logic signed [PROD_W-1:0] deg_sum;
    heading_t                 heading_reg;
    heading_t                 heading_next;

    logic rad_in_range;
    logic deg_in_range;
    logic out_blocked;

    always_comb
    begin
        a_diff = DIFF_W'(pair.from_x) - DIFF_W'(pair.to_x);
        b_diff = DIFF_W'(pair.from_y) - DIFF_W'(pair.to_y);
        a_mag  = a_diff[DIFF_W-1] ? DIFF_W'(-a_diff) : DIFF_W'(a_diff);
        b_mag  = b_diff[DIFF_W-1] ? DIFF_W'(-b_diff) : DIFF_W'(b_diff);

        s0_beat_next.a_neg = a_diff[DIFF_W-1];
        s0_beat_next.b_neg = b_diff[DIFF_W-1];
        s0_beat_next.x     = CORDIC_W'({b_mag, {PRE_SHIFT{1'b0}}});
        s0_beat_next.y     = CORDIC_W'({a_mag, {PRE_SHIFT{1'b0}}});
        s0_beat_next.z     = '0;

        priority if (a_diff == '0)
        begin
            s0_beat_next.mode = b_diff[DIFF_W-1] ? MODE_PI : MODE_ZERO;
        end
        else if (b_diff == '0)
        begin
            s0_beat_next.mode = a_diff[DIFF_W-1] ? MODE_HALF_NEG : MODE_HALF_POS;
        end
        else
        begin
            s0_beat_next.mode = MODE_CORDIC;
        end
    end

    assign pair_ready = !s0_valid_reg || cr[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (pair_ready)
        begin
            s0_valid_reg <= pair_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_ready && pair_valid)
        begin
            s0_beat_reg <= s0_beat_next;
        end
    end

    assign cv[0] = s0_valid_reg;
    assign cd[0] = s0_beat_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        ppha_cordic_stage #(
            .SHIFT (i)
        ) u_rot (
            .clk       (clk),
            .rst_n     (rst_n),
            .src_valid (cv[i]),
            .src_ready (cr[i]),
            .src       (cd[i]),
            .dst_valid (cv[i+1]),
            .dst_ready (cr[i+1]),
            .dst       (cd[i+1])
        );
    end

    // Place the first-quadrant angle in its quadrant
    always_comb
    begin
        theta_half = cd[N].b_neg ? (PI_Q30 - cd[N].z) : cd[N].z;
        unique case (cd[N].mode)
            MODE_ZERO:     theta_next = '0;
            MODE_PI:       theta_next = PI_Q30;
            MODE_HALF_POS: theta_next = HALF_PI_Q30;
            MODE_HALF_NEG: theta_next = -HALF_PI_Q30;
            MODE_CORDIC:   theta_next = cd[N].a_neg ? -theta_half : theta_half;
            default:       theta_next = '0;
        endcase
    end

    assign q_ready = !q_valid_reg || m_ready;
    assign cr[N]   = q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (q_ready)
        begin
            q_valid_reg <= cv[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_ready && cv[N])
        begin
            theta_reg <= theta_next;
        end
    end

    assign neg_theta = -theta_reg;
    assign rad_sum   = theta_reg + RAD_ROUND;
    assign rad_next  = rad_sum[RAD_SHIFT +: RAD_W];
    assign prod_next = PROD_W'(neg_theta) * PROD_W'(DEG_PER_RAD_Q24);
    assign m_ready   = !m_valid_reg || o_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (m_ready)
        begin
            m_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_ready && q_valid_reg)
        begin
            rad_reg  <= rad_next;
            prod_reg <= prod_next;
        end
    end

    assign deg_sum                    = prod_reg + DEG_ROUND;
    assign heading_next.angle_radians = rad_reg;
    assign heading_next.angle_degrees = deg_sum[DEG_SHIFT +: DEG_W];
    assign o_ready                    = !o_valid_reg || heading_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && m_valid_reg)
        begin
            heading_reg <= heading_next;
        end
    end

    assign heading_valid = o_valid_reg;
    assign heading       = heading_reg;

    assign rad_in_range = (heading.angle_radians >= -RAD_MAX)
                       && (heading.angle_radians <= RAD_MAX);
    assign deg_in_range = (heading.angle_degrees >= -DEG_MAX)
                       && (heading.angle_degrees <= DEG_MAX);
    assign out_blocked  = heading_valid && !heading_ready && q_valid_reg && m_valid_reg;

    `PPHA_IMPLIES(a_rad_range, heading_valid, rad_in_range)
    `PPHA_IMPLIES(a_deg_range, heading_valid, deg_in_range)
    `PPHA_IMPLIES(a_full_stall, !pair_ready, out_blocked)
    `PPHA_IMPLIES(a_rot_gain, cv[N] && (cd[N].mode == MODE_CORDIC), cd[N].x > 0)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the point-pair heading angle pipeline: directed probes, random pairs.
module testbench
    import ppha_pkg::*;
();

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 5;
    localparam int PAIRS_PER_PHASE = 284;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int DRAIN_CYCLES    = ANGLE_ITERATIONS_DEF + 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PRINT_LIMIT     = 60;
    localparam int N_PROBES        = 22;

    typedef struct {
        int fx;
        int fy;
        int tx;
        int ty;
        bit known;
        int rad;
        int deg;
    } probe_t;

    probe_t probes [N_PROBES] = '{
        '{0, 0, 0, 0, 1, 0, 0},
        '{-32768, 32767, -32768, 32767, 1, 0, 0},
        '{-1, -1, -1, -1, 1, 0, 0},
        '{0, 0, 0, 1, 1, 25736, -23040},
        '{0, -32768, 0, 32767, 1, 25736, -23040},
        '{0, 0, 0, -1, 1, 0, 0},
        '{5, 32767, 5, -32768, 1, 0, 0},
        '{0, 0, 1, 0, 1, -12868, 11520},
        '{0, 0, -1, 0, 1, 12868, -11520},
        '{-32768, 100, 32767, 100, 1, -12868, 11520},
        '{32767, -7, -32768, -7, 1, 12868, -11520},
        '{0, -32768, 1, 32767, 0, 0, 0},
        '{0, -32768, -1, 32767, 0, 0, 0},
        '{0, 0, 1, 1, 0, 0, 0},
        '{0, 0, -1, -1, 0, 0, 0},
        '{0, 0, 1, -1, 0, 0, 0},
        '{0, 0, -1, 1, 0, 0, 0},
        '{-32768, -32768, 32767, 32767, 0, 0, 0},
        '{32767, 32767, -32768, -32768, 0, 0, 0},
        '{32767, -32768, -32768, 32767, 0, 0, 0},
        '{-32768, 32767, 32767, -32768, 0, 0, 0},
        '{-32768, 0, 32767, 1, 0, 0, 0}
    };

    logic     clk = 1'b0;
    logic     rst_n;
    logic     pair_valid;
    logic     pair_ready;
    pair_t    pair;
    logic     heading_valid;
    logic     heading_ready;
    heading_t heading;

    heading_t expected_headings [$];
    heading_t offered_heading;
    heading_t oldest_heading;
    int       send_idle_pct;
    int       recv_stall_pct;
    bit       hold_off_req = 1'b0;
    int       mismatches = 0;
    int       headings_checked = 0;
    int       pairs_sent = 0;
    int       quiet_cycles = 0;

    point_pair_heading_angle_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pair_valid    (pair_valid),
        .pair_ready    (pair_ready),
        .pair          (pair),
        .heading_valid (heading_valid),
        .heading_ready (heading_ready),
        .heading       (heading)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic heading_t heading_of(pair_t p);
        longint   dx;
        longint   dy;
        longint   a;
        longint   b;
        longint   xc;
        longint   yc;
        longint   zc;
        longint   xs;
        longint   ys;
        longint   theta;
        longint   rad;
        longint   deg;
        int       i;
        heading_t h;
        dx = longint'(p.to_x) - longint'(p.from_x);
        dy = longint'(p.to_y) - longint'(p.from_y);
        a = -dx;
        b = -dy;
        if (a == 0)
            theta = (b < 0) ? longint'(PI_Q30) : 0;
        else if (b == 0)
            theta = (a > 0) ? longint'(HALF_PI_Q30) : -longint'(HALF_PI_Q30);
        else
        begin
            xc = ((b < 0) ? -b : b) <<< PRE_SHIFT;
            yc = ((a < 0) ? -a : a) <<< PRE_SHIFT;
            zc = 0;
            for (i = 0; i < ANGLE_ITERATIONS_DEF && i < TABLE_LEN; i++)
            begin
                xs = xc >>> i;
                ys = yc >>> i;
                if (yc > 0)
                begin
                    xc = xc + ys;
                    yc = yc - xs;
                    zc = zc + longint'(ATAN_TABLE[i]);
                end
                else
                begin
                    xc = xc - ys;
                    yc = yc + xs;
                    zc = zc - longint'(ATAN_TABLE[i]);
                end
            end
            theta = (b < 0) ? longint'(PI_Q30) - zc : zc;
            if (a < 0)
                theta = -theta;
        end
        rad = (theta + (longint'(1) <<< 16)) >>> 17;
        deg = ((-theta) * longint'(DEG_PER_RAD_Q24) + (longint'(1) <<< 46)) >>> 47;
        h.angle_radians = rad[15:0];
        h.angle_degrees = deg[15:0];
        return h;
    endfunction

    function automatic logic [15:0] small_offset(int span);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int    roll;
        p = pair_t'({$urandom, $urandom});
        roll = $urandom_range(0, 99);
        if (roll >= 92)
        begin
            p.to_x = p.from_x;
            p.to_y = p.from_y;
        end
        else if (roll >= 80)
        begin
            if ($urandom_range(0, 1))
                p.to_x = p.from_x + small_offset(2);
            else
                p.to_y = p.from_y + small_offset(2);
        end
        else if (roll >= 70)
        begin
            if ($urandom_range(0, 1))
                p.to_x = p.from_x;
            else
                p.to_y = p.from_y;
        end
        else if (roll >= 50)
        begin
            p.to_x = p.from_x + small_offset(4);
            p.to_y = p.from_y + small_offset(4);
        end
        return p;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic offer_pair(pair_t p, heading_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pair_valid <= 1'b0;
            @(posedge clk);
        end
        pair_valid <= 1'b1;
        pair <= p;
        offered_heading <= want;
        @(posedge clk);
        while (!pair_ready)
            @(posedge clk);
    endtask

    task automatic drain_headings();
        pair_valid <= 1'b0;
        @(posedge clk);
        while (expected_headings.size() != 0)
            @(posedge clk);
    endtask

    // Compare the outgoing beat first, then record the incoming one.
    always @(posedge clk)
    begin
        if (rst_n && heading_valid && heading_ready)
        begin
            if (expected_headings.size() == 0)
                report_mismatch($sformatf("unexpected heading rad=%0d deg=%0d",
                                          heading.angle_radians, heading.angle_degrees));
            else
            begin
                oldest_heading = expected_headings.pop_front();
                if (heading.angle_radians !== oldest_heading.angle_radians)
                    report_mismatch($sformatf("heading %0d angle_radians %0d, expected %0d",
                                              headings_checked, heading.angle_radians,
                                              oldest_heading.angle_radians));
                if (heading.angle_degrees !== oldest_heading.angle_degrees)
                    report_mismatch($sformatf("heading %0d angle_degrees %0d, expected %0d",
                                              headings_checked, heading.angle_degrees,
                                              oldest_heading.angle_degrees));
            end
            headings_checked++;
        end
        if (rst_n && pair_valid && pair_ready)
        begin
            expected_headings.push_back(offered_heading);
            pairs_sent++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pair_valid && pair_ready) || (heading_valid && heading_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d headings outstanding",
                         quiet_cycles, expected_headings.size());
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        heading_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                heading_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                heading_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        pair_t    stim;
        heading_t want;
        int       phase;
        int       n;
        rst_n = 1'b0;
        pair_valid = 1'b0;
        pair = '0;
        offered_heading = '0;
        send_idle_pct = 15;
        recv_stall_pct = 48;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[k])
        begin
            stim.from_x = 16'(probes[k].fx);
            stim.from_y = 16'(probes[k].fy);
            stim.to_x = 16'(probes[k].tx);
            stim.to_y = 16'(probes[k].ty);
            if (probes[k].known)
            begin
                want.angle_radians = 16'(probes[k].rad);
                want.angle_degrees = 16'(probes[k].deg);
            end
            else
                want = heading_of(stim);
            offer_pair(stim, want);
        end

        for (phase = 0; phase < 3; phase++)
        begin
            drain_headings();
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 48 : 0;
            recv_stall_pct = (phase == 0) ? 48 : (phase == 1) ? 15 : 0;
            for (n = 0; n < PAIRS_PER_PHASE; n++)
            begin
                if (phase == 2 && n == 40)
                    hold_off_req = 1'b1;
                stim = random_pair();
                offer_pair(stim, heading_of(stim));
            end
        end

        drain_headings();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("summary: %0d point pairs (%0d directed), three idle mixes, %0d-cycle hold-off",
                 pairs_sent, N_PROBES, HOLD_OFF_CYCLES);
        $display("summary: %0d headings compared, %0d mismatches", headings_checked, mismatches);
        if (mismatches == 0 && expected_headings.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
